// File: rtl/kdrq_pkg.sv
`default_nettype none

package kdrq_pkg;

  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned NumKeysDef    = 4;
  localparam int unsigned RawKeysW      = 4;
  localparam int unsigned CodeW         = 2;
  localparam int unsigned CntrW         = 8;
  localparam int unsigned VoteSamples   = 3;
  localparam int unsigned PhaseW        = 2;
  localparam int unsigned AddrW         = 3;
  localparam int unsigned DataW         = 32;

  localparam logic [CntrW-1:0] RepeatDelayRst  = 8'd75;
  localparam logic [CntrW-1:0] RepeatPeriodRst = 8'd10;

  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(VoteSamples - 1);

  localparam logic ActSample = 1'b0;
  localparam logic ActRead   = 1'b1;

  localparam logic RegDelay  = 1'b0;
  localparam logic RegPeriod = 1'b1;

  typedef struct packed {
    logic                action;
    logic [RawKeysW-1:0] raw_keys;
  } in_word_t;

  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic             key_valid;
  } out_word_t;

  typedef struct packed {
    logic              sample;
    logic              decide;
    logic [PhaseW-1:0] phase;
  } lane_ctrl_t;

  typedef struct packed {
    logic             empty;
    logic [CodeW-1:0] head_code;
  } queue_status_t;

  function automatic logic majority3(input logic [VoteSamples-1:0] h);
    majority3 = (h[0] & h[1]) | (h[0] & h[2]) | (h[1] & h[2]);
  endfunction

endpackage

`default_nettype wire

// File: rtl/kdrq_lane.sv
`default_nettype none

module kdrq_lane
  import kdrq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lane_ctrl_t       ctrl_i,
  input  wire logic             raw_bit_i,
  input  wire logic [CntrW-1:0] repeat_delay_i,
  input  wire logic [CntrW-1:0] repeat_period_i,
  output logic                  push_o
);

  logic [VoteSamples-1:0] hist_q, hist_d;
  logic                   deb_q, deb_d;
  logic [CntrW-1:0]       delay_q, delay_d;
  logic [CntrW-1:0]       period_q, period_d;
  logic [CntrW-1:0]       period_dec;
  logic                   vote;

  always_comb begin
    hist_d     = hist_q;
    deb_d      = deb_q;
    delay_d    = delay_q;
    period_d   = period_q;
    period_dec = period_q - 8'd1;
    push_o     = 1'b0;
    if (ctrl_i.sample) begin
      hist_d[ctrl_i.phase] = raw_bit_i;
    end
    vote = majority3(hist_d);
    if (ctrl_i.decide) begin
      deb_d = vote;
      if (vote) begin
        if (!deb_q) begin
          push_o = 1'b1;
        end else if (delay_q != '0) begin
          delay_d = delay_q - 8'd1;
        end else if (period_dec == '0) begin
          period_d = repeat_period_i;
          push_o   = 1'b1;
        end else begin
          period_d = period_dec;
        end
      end else begin
        delay_d = repeat_delay_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      deb_q    <= 1'b0;
      delay_q  <= RepeatDelayRst;
      period_q <= RepeatPeriodRst;
    end else begin
      hist_q   <= hist_d;
      deb_q    <= deb_d;
      delay_q  <= delay_d;
      period_q <= period_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/kdrq_queue.sv
`default_nettype none

module kdrq_queue
  import kdrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned NUM_KEYS    = NumKeysDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [NUM_KEYS-1:0] push_i,
  input  wire logic                pop_i,
  output queue_status_t            status_o
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = $clog2(QUEUE_DEPTH + NUM_KEYS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);

  logic [CodeW-1:0] mem_q [QUEUE_DEPTH];
  logic [CodeW-1:0] mem_d [QUEUE_DEPTH];
  logic [IdxW-1:0]  head_q, head_d;
  logic [IdxW-1:0]  tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SumW-1:0]  sum;

  always_comb begin
    mem_d   = mem_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    sum     = SumW'(count_q);
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (push_i[k]) begin
        mem_d[tail_d] = CodeW'(k);
        tail_d        = (tail_d == LastIdx) ? '0 : tail_d + 1'b1;
        sum           = sum + 1'b1;
      end
    end
    if (push_i != '0) begin
      if (sum >= SumW'(QUEUE_DEPTH)) begin
        count_d = CntW'(QUEUE_DEPTH);
        head_d  = tail_d;
      end else begin
        count_d = sum[CntW-1:0];
      end
    end else if (pop_i && count_q != '0) begin
      head_d  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    mem_q <= mem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign status_o.empty     = (count_q == '0);
  assign status_o.head_code = mem_q[head_q];

endmodule

`default_nettype wire

// File: rtl/keypad_debounce_repeat_queue_top.sv
// Channel  Direction  Handshake             Word
// in       sink       in_valid_i/in_stall_o  in_word_t  (action, raw_keys)
// out      source     out_valid_o/out_stall_i out_word_t (key_code, key_valid)
// cfg      APB        psel/penable/pready   repeat_delay @0x0, repeat_period @0x4
//
// One word per cycle unless stalled; sample and vote update lanes and queue together.
// A read word answers in the cycle after acceptance, from the output register.
// A sample word is taken while a result waits; a read word waits for the output register.
// Reset clears history, queue pointers and the output valid; counters take reset values.
`default_nettype none

module keypad_debounce_repeat_queue_top
  import kdrq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned NUM_KEYS    = NumKeysDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_word_t         in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_word_t             out_data_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);

  logic [CntrW-1:0]    delay_q, period_q;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic                out_valid_q;
  out_word_t           out_data_q;
  logic                in_acc, rd_acc, cfg_wr;
  lane_ctrl_t          ctrl;
  logic [NUM_KEYS-1:0] push;
  queue_status_t       qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegPeriod) ? DataW'(period_q) : DataW'(delay_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= RepeatDelayRst;
      period_q <= RepeatPeriodRst;
    end else if (cfg_wr) begin
      if (paddr[2] == RegDelay) begin
        delay_q <= pwdata[CntrW-1:0];
      end else begin
        period_q <= pwdata[CntrW-1:0];
      end
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i & (in_data_i.action == ActRead);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign rd_acc     = in_acc & (in_data_i.action == ActRead);

  assign ctrl.sample = in_acc & (in_data_i.action == ActSample);
  assign ctrl.phase  = phase_q;
  assign ctrl.decide = ctrl.sample & (phase_q == PhaseLast);
  assign phase_d     = ctrl.decide ? '0 : phase_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctrl.sample) begin
      phase_q <= phase_d;
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic raw_bit;
    if (k < RawKeysW) begin : g_pin
      assign raw_bit = in_data_i.raw_keys[k];
    end else begin : g_none
      assign raw_bit = 1'b0;
    end
    kdrq_lane u_lane (
      .clk_i,
      .rst_ni,
      .ctrl_i          (ctrl),
      .raw_bit_i       (raw_bit),
      .repeat_delay_i  (delay_q),
      .repeat_period_i (period_q),
      .push_o          (push[k])
    );
  end

  kdrq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_KEYS    (NUM_KEYS)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .pop_i    (rd_acc),
    .status_o (qstat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      out_data_q.key_valid <= ~qstat.empty;
      out_data_q.key_code  <= qstat.empty ? '0 : qstat.head_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> out_valid_q)
    else $error("read word gave no result");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc && qstat.empty |=> !out_data_q.key_valid && out_data_q.key_code == '0)
    else $error("empty read reported a code");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rd_acc |=> $stable(out_data_q))
    else $error("result changed without a read");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhaseLast)
    else $error("sample phase out of range");

  a_push_on_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push != '0 |-> ctrl.decide)
    else $error("key code queued outside a vote");

endmodule

`default_nettype wire
